FILE: design/tasp_pkg.sv
// Shared types and constants for the three-axis step pulse ramp generator.
// No dependencies; imported by three_axis_step_pulse_ramp_top and its testbench.
package tasp_pkg;

  // Operation codes carried on in_tuser
  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_LOAD  = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  localparam int FUNC_W     = 2;
  localparam int AXIS_W     = 2;
  localparam int STEPS_W    = 24;
  localparam int PERIOD_W   = 32;
  localparam int RAMP_W     = 24;
  localparam int LIMIT_W    = 3;
  localparam int OUT_AXES   = 3;
  localparam int OUT_EDGE_W = 25;
  localparam int ELAPSED_W  = 56;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;

  // One accepted input word, unpacked
  typedef struct packed {
    logic                stop_input;
    logic [LIMIT_W-1:0]  limit_inputs;
    logic                move_direction;
    logic [RAMP_W-1:0]   ramp_steps;
    logic [PERIOD_W-1:0] step_period;
    logic [STEPS_W-1:0]  step_total;
    logic [AXIS_W-1:0]   axis;
    logic [FUNC_W-1:0]   func;
  } item_t;

endpackage

FILE: design/three_axis_step_pulse_ramp_top.sv
// Three-axis step pulse generator with trapezoidal speed ramp, top level.
// Depends on tasp_pkg for the operation codes, field widths and item type.
//
// Usage:
//   The in_ channel carries one word per timer tick, move load or flag clear;
//   in_tuser selects which, in_tdata carries the remaining fields. Every
//   accepted word produces exactly one out_ word with the pin levels, busy
//   and sticky limit flags, the load reject flag and the per-axis edge counts
//   after that word took effect.
//   Throughput: one word per cycle unless the receiver stalls; there is one input register
//   and one result register, and all per-axis work for a word (threshold
//   compare, edge count, ramp factor and threshold update) fits in the path
//   between them. The ramp threshold is kept as a running product
//   half_period * ramp_factor, so only a load uses the multiplier.
//   When the receiver stalls, the result register holds its word, the input
//   register fills, and in_tready drops until out_tready returns.
//   Reset (rst_n low, synchronous) idles every axis, drives all pins low,
//   clears the sticky limit flags and empties both registers.
module three_axis_step_pulse_ramp_top #(
  parameter int AXES        = 3,
  parameter int STEP_BITS   = 24,
  parameter int PERIOD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] axis, [25:2] step_total, [57:26] step_period, [81:58] ramp_steps,
  // [82] move_direction, [85:83] limit_inputs, [86] stop_input, [87] zero
  input  logic [tasp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [tasp_pkg::FUNC_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] pulse_levels, [5:3] direction_levels, [8:6] busy_flags,
  // [11:9] limit_flags, [12] load_rejected, [37:13] edges_axis_one,
  // [62:38] edges_axis_two, [87:63] edges_axis_three
  output logic [tasp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tasp_pkg::*;

  localparam int TGT_W = STEP_BITS + 1;
  localparam int HP_W  = PERIOD_BITS - 1;
  localparam int THR_W = HP_W + TGT_W;
  localparam int CMP_W = (THR_W > ELAPSED_W) ? THR_W : ELAPSED_W;

  // Input and result registers
  item_t                 item_r;
  logic                  item_v_r;
  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  advance;

  // Per-axis move state
  logic [TGT_W-1:0]     tgt_r    [AXES];
  logic [HP_W-1:0]      hp_r     [AXES];
  logic [STEP_BITS-1:0] rlen_r   [AXES];
  logic [TGT_W-1:0]     decel_r  [AXES];
  logic [TGT_W-1:0]     factor_r [AXES];
  logic [THR_W-1:0]     thr_r    [AXES];
  logic [TGT_W-1:0]     cnt_r    [AXES];
  logic [ELAPSED_W-1:0] el_r     [AXES];
  logic [AXES-1:0]      pulse_r, dir_r, busy_r;
  logic [LIMIT_W-1:0]   limits_r;

  logic [TGT_W-1:0]     tgt_nxt    [AXES];
  logic [HP_W-1:0]      hp_nxt     [AXES];
  logic [STEP_BITS-1:0] rlen_nxt   [AXES];
  logic [TGT_W-1:0]     decel_nxt  [AXES];
  logic [TGT_W-1:0]     factor_nxt [AXES];
  logic [THR_W-1:0]     thr_nxt    [AXES];
  logic [TGT_W-1:0]     cnt_nxt    [AXES];
  logic [ELAPSED_W-1:0] el_nxt     [AXES];
  logic [AXES-1:0]      pulse_nxt, dir_nxt, busy_nxt;
  logic [LIMIT_W-1:0]   limits_nxt;
  logic                 rejected;
  logic                 limit_hit;

  // Load operands, shared by all axes
  logic [STEP_BITS-1:0] ld_steps;
  logic [STEP_BITS-1:0] ld_ramp;
  logic [HP_W-1:0]      ld_hp;
  logic [TGT_W-1:0]     ld_tgt;
  logic [TGT_W-1:0]     ld_decel;
  logic [THR_W-1:0]     ld_thr;

  logic [OUT_EDGE_W-1:0] edge_out [OUT_AXES];
  logic [AXES+OUT_AXES-1:0] pulse_ext, dir_ext, busy_ext;

  // Advance when the result register is empty or being drained
  assign advance   = item_v_r && (!out_v_r || out_tready);
  assign in_tready = !item_v_r || advance;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  assign limit_hit = (item_r.limit_inputs != '0) || item_r.stop_input;

  assign ld_steps = STEP_BITS'(item_r.step_total);
  assign ld_ramp  = STEP_BITS'(item_r.ramp_steps);
  assign ld_hp    = HP_W'(PERIOD_BITS'(item_r.step_period) >> 1);
  assign ld_tgt   = {ld_steps, 1'b0};
  assign ld_decel = (ld_tgt > TGT_W'(ld_ramp)) ? (ld_tgt - TGT_W'(ld_ramp)) : '0;
  // Initial threshold: half period times initial ramp factor
  assign ld_thr   = THR_W'(ld_hp) * THR_W'(ld_ramp);

  always_comb begin
    tgt_nxt    = tgt_r;
    hp_nxt     = hp_r;
    rlen_nxt   = rlen_r;
    decel_nxt  = decel_r;
    factor_nxt = factor_r;
    thr_nxt    = thr_r;
    cnt_nxt    = cnt_r;
    el_nxt     = el_r;
    pulse_nxt  = pulse_r;
    dir_nxt    = dir_r;
    busy_nxt   = busy_r;
    rejected   = 1'b0;

    limits_nxt = (func_t'(item_r.func) == FN_CLEAR) ? '0 : limits_r;

    if (limit_hit) begin
      // Latch the limit sources and abort every move, directions kept
      limits_nxt = limits_nxt | item_r.limit_inputs |
                   {item_r.stop_input, {(LIMIT_W-1){1'b0}}};
      for (int a = 0; a < AXES; a++) begin
        busy_nxt[a]  = 1'b0;
        pulse_nxt[a] = 1'b0;
        cnt_nxt[a]   = '0;
        el_nxt[a]    = '0;
      end
    end else begin
      case (func_t'(item_r.func))
        FN_TICK: begin
          for (int a = 0; a < AXES; a++) begin
            if (busy_r[a]) begin
              el_nxt[a] = (el_r[a] != '1) ? el_r[a] + 1'b1 : el_r[a];
              if (CMP_W'(el_nxt[a]) >= CMP_W'(thr_r[a])) begin
                pulse_nxt[a] = ~pulse_r[a];
                el_nxt[a]    = '0;
                cnt_nxt[a]   = cnt_r[a] + 1'b1;
                // Step the ramp factor and keep the threshold in line with it
                if (cnt_nxt[a] < TGT_W'(rlen_r[a])) begin
                  if (factor_r[a] != '0) begin
                    factor_nxt[a] = factor_r[a] - 1'b1;
                    thr_nxt[a]    = thr_r[a] - THR_W'(hp_r[a]);
                  end
                end else if (cnt_nxt[a] < decel_r[a]) begin
                  factor_nxt[a] = TGT_W'(1);
                  thr_nxt[a]    = THR_W'(hp_r[a]);
                end else if (factor_r[a] != '1) begin
                  factor_nxt[a] = factor_r[a] + 1'b1;
                  thr_nxt[a]    = thr_r[a] + THR_W'(hp_r[a]);
                end
              end
              if (cnt_nxt[a] == tgt_r[a]) begin
                pulse_nxt[a] = 1'b0;
                busy_nxt[a]  = 1'b0;
                cnt_nxt[a]   = '0;
                el_nxt[a]    = '0;
              end
            end
          end
        end
        FN_LOAD: begin
          if (busy_r != '0) begin
            rejected = 1'b1;
          end else begin
            for (int a = 0; a < AXES; a++) begin
              if (int'(item_r.axis) == a) begin
                tgt_nxt[a]    = ld_tgt;
                hp_nxt[a]     = ld_hp;
                rlen_nxt[a]   = ld_ramp;
                decel_nxt[a]  = ld_decel;
                factor_nxt[a] = TGT_W'(ld_ramp);
                thr_nxt[a]    = ld_thr;
                cnt_nxt[a]    = '0;
                el_nxt[a]     = '0;
                pulse_nxt[a]  = 1'b0;
                dir_nxt[a]    = item_r.move_direction;
                busy_nxt[a]   = (ld_tgt != '0);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields; axes past the third are not reported, missing ones read zero
  assign pulse_ext = {{OUT_AXES{1'b0}}, pulse_nxt};
  assign dir_ext   = {{OUT_AXES{1'b0}}, dir_nxt};
  assign busy_ext  = {{OUT_AXES{1'b0}}, busy_nxt};

  for (genvar g = 0; g < OUT_AXES; g++) begin : g_edge_out
    if (g < AXES) begin : g_real
      assign edge_out[g] = OUT_EDGE_W'(cnt_nxt[g]);
    end else begin : g_none
      assign edge_out[g] = '0;
    end
  end

  assign out_data_nxt = {edge_out[2], edge_out[1], edge_out[0], rejected, limits_nxt,
                         busy_ext[OUT_AXES-1:0], dir_ext[OUT_AXES-1:0],
                         pulse_ext[OUT_AXES-1:0]};

  // Payload registers: take the word on accept, the result on advance
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func           <= in_tuser;
      item_r.axis           <= in_tdata[1:0];
      item_r.step_total     <= in_tdata[25:2];
      item_r.step_period    <= in_tdata[57:26];
      item_r.ramp_steps     <= in_tdata[81:58];
      item_r.move_direction <= in_tdata[82];
      item_r.limit_inputs   <= in_tdata[85:83];
      item_r.stop_input     <= in_tdata[86];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Control and move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      pulse_r  <= '0;
      dir_r    <= '0;
      busy_r   <= '0;
      limits_r <= '0;
      for (int a = 0; a < AXES; a++) begin
        tgt_r[a]    <= '0;
        hp_r[a]     <= '0;
        rlen_r[a]   <= '0;
        decel_r[a]  <= '0;
        factor_r[a] <= '0;
        thr_r[a]    <= '0;
        cnt_r[a]    <= '0;
        el_r[a]     <= '0;
      end
    end else begin
      if (in_tready) begin
        item_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r    <= 1'b1;
        tgt_r      <= tgt_nxt;
        hp_r       <= hp_nxt;
        rlen_r     <= rlen_nxt;
        decel_r    <= decel_nxt;
        factor_r   <= factor_nxt;
        thr_r      <= thr_nxt;
        cnt_r      <= cnt_nxt;
        el_r       <= el_nxt;
        pulse_r    <= pulse_nxt;
        dir_r      <= dir_nxt;
        busy_r     <= busy_nxt;
        limits_r   <= limits_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // A limit or stop word leaves every axis idle
  a_abort_idles: assert property (@(posedge clk) disable iff (!rst_n)
    advance && limit_hit |=> busy_r == '0)
    else $error("axis still busy after limit abort");

  // A rejected load in the result register implies some axis is still busy
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_data_r[12] |-> busy_r != '0)
    else $error("load rejected while all axes idle");

  for (genvar g = 0; g < AXES; g++) begin : g_axis_chk
    // An idle axis holds its pulse pin low
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
      !busy_r[g] |-> !pulse_r[g])
      else $error("pulse high on idle axis");
    // A busy axis has not yet reached its edge target
    a_cnt_below: assert property (@(posedge clk) disable iff (!rst_n)
      busy_r[g] |-> cnt_r[g] < tgt_r[g])
      else $error("edge count reached target on busy axis");
  end

endmodule

FILE: sim/tb_three_axis_step_pulse_ramp_top.sv
// Self-checking testbench for three_axis_step_pulse_ramp_top: a directed table,
// then random moves, checked word by word against a built-in axis predictor.
// Depends on tasp_pkg (operation codes, field widths, input item type).
module tb_three_axis_step_pulse_ramp_top;
  import tasp_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [FUNC_W-1:0] FN_NOP            = 2'd3;
  localparam logic [AXIS_W-1:0] AXIS_OUT_OF_RANGE = 2'd3;

  // One out_tdata word, lowest field last
  typedef struct packed {
    logic [OUT_EDGE_W-1:0] edges_three;
    logic [OUT_EDGE_W-1:0] edges_two;
    logic [OUT_EDGE_W-1:0] edges_one;
    logic                  rejected;
    logic [2:0]            limits;
    logic [2:0]            busy;
    logic [2:0]            dirs;
    logic [2:0]            pulses;
  } pins_t;

  typedef struct {
    item_t word;
    int    reps;
    bit    typed;
    pins_t want;
  } stim_row_t;

  typedef enum int {RX_STREAM, RX_CHOPPY, RX_HOLD} rx_mode_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]     in_tuser   = FN_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  three_axis_step_pulse_ramp_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicted axis state, one entry per axis
  logic [OUT_EDGE_W-1:0] target_edges [3];
  logic [30:0]           half_per     [3];
  logic [RAMP_W-1:0]     ramp_len     [3];
  logic [OUT_EDGE_W-1:0] decel_at     [3];
  logic [OUT_EDGE_W-1:0] ramp_fac     [3];
  logic [OUT_EDGE_W-1:0] edges_done   [3];
  logic [ELAPSED_W-1:0]  ticks_since  [3];
  logic [2:0]            pulse_pins;
  logic [2:0]            dir_pins;
  logic [2:0]            moving;
  logic [2:0]            limit_latch;

  pins_t     pin_words_q[$];
  stim_row_t stim_table[$];
  int        mismatches = 0;
  int        burst_left = 0;

  // Advance the predicted generator by one accepted word and return its output word.
  task automatic predict_pins(input item_t it, output pins_t r);
    logic [ELAPSED_W-1:0]  thr;
    logic [OUT_EDGE_W-1:0] tgt;
    logic                  rej;
    rej = 1'b0;
    if (it.func == FN_CLEAR) limit_latch = '0;
    if (it.limit_inputs != '0 || it.stop_input) begin
      // Latch the flags and abort every move; directions stay
      limit_latch = limit_latch | it.limit_inputs | {it.stop_input, 2'b00};
      for (int a = 0; a < 3; a++) begin
        edges_done[a]  = '0;
        ticks_since[a] = '0;
      end
      moving     = '0;
      pulse_pins = '0;
    end else if (it.func == FN_TICK) begin
      for (int a = 0; a < 3; a++) begin
        if (moving[a]) begin
          if (ticks_since[a] != '1) ticks_since[a]++;
          thr = {25'd0, half_per[a]} * {31'd0, ramp_fac[a]};
          if (ticks_since[a] >= thr) begin
            pulse_pins[a]  = ~pulse_pins[a];
            ticks_since[a] = '0;
            edges_done[a]++;
            // Accelerate, cruise, then decelerate with saturation at all ones
            if (edges_done[a] < {1'b0, ramp_len[a]}) begin
              if (ramp_fac[a] != '0) ramp_fac[a]--;
            end else if (edges_done[a] < decel_at[a]) begin
              ramp_fac[a] = 1;
            end else if (ramp_fac[a] != '1) begin
              ramp_fac[a]++;
            end
          end
          if (edges_done[a] == target_edges[a]) begin
            pulse_pins[a]  = 1'b0;
            moving[a]      = 1'b0;
            edges_done[a]  = '0;
            ticks_since[a] = '0;
          end
        end
      end
    end else if (it.func == FN_LOAD) begin
      if (moving != '0) begin
        rej = 1'b1;
      end else if (it.axis != AXIS_OUT_OF_RANGE) begin
        tgt = {it.step_total, 1'b0};
        target_edges[it.axis] = tgt;
        half_per[it.axis]     = it.step_period[PERIOD_W-1:1];
        ramp_len[it.axis]     = it.ramp_steps;
        decel_at[it.axis]     = (tgt > {1'b0, it.ramp_steps}) ?
                                tgt - {1'b0, it.ramp_steps} : '0;
        ramp_fac[it.axis]     = {1'b0, it.ramp_steps};
        edges_done[it.axis]   = '0;
        ticks_since[it.axis]  = '0;
        pulse_pins[it.axis]   = 1'b0;
        dir_pins[it.axis]     = it.move_direction;
        moving[it.axis]       = (tgt != '0);
      end
    end
    r.pulses      = pulse_pins;
    r.dirs        = dir_pins;
    r.busy        = moving;
    r.limits      = limit_latch;
    r.rejected    = rej;
    r.edges_one   = edges_done[0];
    r.edges_two   = edges_done[1];
    r.edges_three = edges_done[2];
  endtask

  function automatic item_t make_word(logic [FUNC_W-1:0] fn, logic [AXIS_W-1:0] ax,
                                      logic [STEPS_W-1:0] steps, logic [PERIOD_W-1:0] per,
                                      logic [RAMP_W-1:0] ramp, logic dir,
                                      logic [LIMIT_W-1:0] lim, logic stop);
    item_t it;
    it.func           = fn;
    it.axis           = ax;
    it.step_total     = steps;
    it.step_period    = per;
    it.ramp_steps     = ramp;
    it.move_direction = dir;
    it.limit_inputs   = lim;
    it.stop_input     = stop;
    return it;
  endfunction

  // Output word with all edge counters at zero
  function automatic pins_t idle_pins(logic [2:0] pulses, logic [2:0] dirs, logic [2:0] busy,
                                      logic [2:0] limits, logic rej);
    pins_t r;
    r             = '0;
    r.pulses      = pulses;
    r.dirs        = dirs;
    r.busy        = busy;
    r.limits      = limits;
    r.rejected    = rej;
    return r;
  endfunction

  task automatic add_row(input item_t it, input int reps, input bit typed, input pins_t want);
    stim_row_t row;
    row.word  = it;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // Send one word, honoring the burst/gap pattern; queue its expected output word.
  task automatic send_word(input item_t it, input bit typed, input pins_t want);
    pins_t r;
    int    gap;
    if (burst_left == 0) begin
      // Hold off for a random gap, or none, then start a new burst
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it[$bits(item_t)-1:FUNC_W]};
    in_tuser  <= it.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pins(it, r);
    pin_words_q.push_back(typed ? want : r);
    burst_left--;
  endtask

  // Pause the sender until every expected word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pin_words_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [OUT_EDGE_W-1:0] want,
                             input logic [OUT_EDGE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Compare every accepted output word with the oldest expectation
  always @(posedge clk) begin
    pins_t want;
    pins_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pin_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("output word with nothing expected: %h", out_tdata);
      end else begin
        want = pin_words_q.pop_front();
        check_field("pulse_levels", OUT_EDGE_W'(want.pulses), OUT_EDGE_W'(got.pulses));
        check_field("direction_levels", OUT_EDGE_W'(want.dirs), OUT_EDGE_W'(got.dirs));
        check_field("busy_flags", OUT_EDGE_W'(want.busy), OUT_EDGE_W'(got.busy));
        check_field("limit_flags", OUT_EDGE_W'(want.limits), OUT_EDGE_W'(got.limits));
        check_field("load_rejected", OUT_EDGE_W'(want.rejected),
                    OUT_EDGE_W'(got.rejected));
        check_field("edges_axis_one", want.edges_one, got.edges_one);
        check_field("edges_axis_two", want.edges_two, got.edges_two);
        check_field("edges_axis_three", want.edges_three, got.edges_three);
      end
    end
  end

  // Receiver: free-running stretches, choppy stretches and long holds
  rx_mode_t rx_mode = RX_STREAM;
  int       rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      case (rx_mode)
        RX_STREAM: rx_left = $urandom_range(20, 200);
        RX_CHOPPY: rx_left = $urandom_range(10, 100);
        default:   rx_left = $urandom_range(1, 30);
      endcase
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM: out_tready <= 1'b1;
      RX_CHOPPY: out_tready <= 1'($urandom_range(0, 1));
      default:   out_tready <= 1'b0;
    endcase
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("tb_three_axis_step_pulse_ramp_top: FAIL");
    $finish;
  end

  initial begin
    item_t it;
    pins_t none;
    int    counted;
    int    move_ticks;
    int    pick;
    int    waited;
    bit    drained_mid;

    none        = '0;
    counted     = 0;
    move_ticks  = 0;
    drained_mid = 1'b0;
    for (int a = 0; a < 3; a++) begin
      target_edges[a] = '0;
      half_per[a]     = '0;
      ramp_len[a]     = '0;
      decel_at[a]     = '0;
      ramp_fac[a]     = '0;
      edges_done[a]   = '0;
      ticks_since[a]  = '0;
    end
    pulse_pins  = '0;
    dir_pins    = '0;
    moving      = '0;
    limit_latch = '0;

    // Directed table: typed-in outputs only where they are obvious
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 1, none);
    add_row(make_word(FN_NOP, 0, 0, 0, 0, 0, 0, 0), 1, 1, none);
    add_row(make_word(FN_LOAD, AXIS_OUT_OF_RANGE, '1, '1, '1, 1, 0, 0), 1, 1, none);
    // Zero threshold: half period zero, toggle on every tick
    add_row(make_word(FN_LOAD, 0, 2, 1, 0, 1, 0, 0), 1, 1,
            idle_pins(3'b000, 3'b001, 3'b001, 3'b000, 1'b0));
    add_row(make_word(FN_LOAD, 1, 5, 9, 2, 0, 0, 0), 1, 1,
            idle_pins(3'b000, 3'b001, 3'b001, 3'b000, 1'b1));
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 0, 0), 4, 0, none);
    // Ramp longer than the move: deceleration starts at zero
    add_row(make_word(FN_LOAD, 2, 1, 5, 5, 1, 0, 0), 1, 0, none);
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 0, 0), 20, 0, none);
    // Extreme move, aborted by all limit inputs
    add_row(make_word(FN_LOAD, 1, '1, '1, '1, 0, 0, 0), 1, 0, none);
    add_row(make_word(FN_TICK, 3, '1, '1, '1, 1, 0, 0), 3, 0, none);
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 3'b111, 0), 1, 1,
            idle_pins(3'b000, 3'b101, 3'b000, 3'b111, 1'b0));
    // Clear then stop in the same word: only the stop flag remains
    add_row(make_word(FN_CLEAR, 0, 0, 0, 0, 0, 0, 1), 1, 1,
            idle_pins(3'b000, 3'b101, 3'b000, 3'b100, 1'b0));
    add_row(make_word(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 1,
            idle_pins(3'b000, 3'b101, 3'b000, 3'b000, 1'b0));
    // Load blocked by a limit input: not performed, not rejected
    add_row(make_word(FN_LOAD, 0, 3, 2, 1, 0, 3'b010, 0), 1, 1,
            idle_pins(3'b000, 3'b101, 3'b000, 3'b010, 1'b0));
    add_row(make_word(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 1,
            idle_pins(3'b000, 3'b101, 3'b000, 3'b000, 1'b0));
    // Full trapezoid: accelerate, cruise, decelerate
    add_row(make_word(FN_LOAD, 0, 3, 6, 2, 0, 0, 0), 1, 0, none);
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 0, 0), 40, 0, none);
    // Zero steps: state loaded, axis stays idle
    add_row(make_word(FN_LOAD, 1, 0, 9, 3, 1, 0, 0), 1, 0, none);
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 0, 0), 2, 0, none);
    // Ramp factor zero with a nonzero half period
    add_row(make_word(FN_LOAD, 2, 2, 4, 0, 0, 0, 0), 1, 0, none);
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 0, 0), 12, 0, none);
    add_row(make_word(FN_TICK, 0, 0, 0, 0, 0, 0, 1), 1, 0, none);
    add_row(make_word(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 0, none);

    // Reset, synchronous, once
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i])
      repeat (stim_table[i].reps) send_word(stim_table[i].word, stim_table[i].typed,
                                            stim_table[i].want);
    wait_drained();

    // Random moves: mostly well-formed load-then-tick runs, some noise and aborts
    while (counted < 800) begin
      if (counted >= 400 && !drained_mid) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      it.func           = FN_TICK;
      it.axis           = AXIS_W'($urandom_range(0, 3));
      it.step_total     = STEPS_W'($urandom);
      it.step_period    = $urandom;
      it.ramp_steps     = RAMP_W'($urandom);
      it.move_direction = 1'($urandom_range(0, 1));
      it.limit_inputs   = '0;
      it.stop_input     = 1'b0;
      pick = $urandom_range(0, 99);
      if (moving == '0) begin
        if (pick < 5) begin
          // Large random move, usually cut short by an abort
          it.func = FN_LOAD;
          it.axis = AXIS_W'($urandom_range(0, 2));
          move_ticks = 0;
          counted++;
        end else if (pick < 12) begin
          case ($urandom_range(0, 3))
            0:       it.func = FN_NOP;
            1:       it.func = FN_LOAD;
            2:       it.func = FN_TICK;
            default: begin
              it.func = FN_CLEAR;
              counted++;
            end
          endcase
          if (it.func == FN_LOAD) it.axis = AXIS_OUT_OF_RANGE;
        end else begin
          it.func        = FN_LOAD;
          it.axis        = AXIS_W'($urandom_range(0, 2));
          it.step_total  = STEPS_W'($urandom_range(0, 6));
          it.step_period = $urandom_range(0, 5);
          it.ramp_steps  = RAMP_W'($urandom_range(0, 4));
          move_ticks     = 0;
          counted++;
        end
        if ($urandom_range(0, 49) == 0) it.limit_inputs = LIMIT_W'($urandom_range(1, 7));
      end else begin
        counted++;
        move_ticks++;
        if (move_ticks > 150 || pick == 0) begin
          // Abort the move with limit inputs, stop, or both
          it.limit_inputs = LIMIT_W'($urandom_range(0, 7));
          it.stop_input   = 1'($urandom_range(0, 1));
          if (it.limit_inputs == '0) it.stop_input = 1'b1;
        end else if (pick < 4) begin
          case ($urandom_range(0, 2))
            0:       it.func = FN_LOAD;
            1:       it.func = FN_NOP;
            default: it.func = FN_CLEAR;
          endcase
          if (it.func != FN_CLEAR) counted--;
        end
      end
      send_word(it, 1'b0, none);
    end

    // Drain with a limit, then let the pipeline settle
    in_tvalid <= 1'b0;
    waited = 0;
    while (pin_words_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pin_words_q.size() == 0) begin
      $display("tb_three_axis_step_pulse_ramp_top: PASS");
    end else begin
      $display("tb_three_axis_step_pulse_ramp_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tasp_pkg.sv
design/three_axis_step_pulse_ramp_top.sv
sim/tb_three_axis_step_pulse_ramp_top.sv
